/* hdl/cal_pkg.sv */
// ----------------------------------------------------------------------------
// cal_pkg
// Shared types, constants and calendar helper functions for the
// calendar date counter.
// ----------------------------------------------------------------------------
package cal_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;

  localparam logic [YearW-1:0]  YearMinLoad  = 14'd1900;
  localparam logic [YearW-1:0]  YearMax      = 14'd9999;
  localparam logic [YearW-1:0]  DefaultYear  = 14'd2023;
  localparam logic [MonthW-1:0] DefaultMonth = 4'd1;
  localparam logic [DayW-1:0]   DefaultDay   = 5'd1;

  // reciprocal of 25 scaled by 2^20, exact floor for all 14-bit years
  localparam int unsigned    Recip25Shift = 20;
  localparam logic [15:0]    Recip25      = 16'd41944;

  // request kinds
  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_INC  = 2'd1,
    KIND_DEC  = 2'd2
  } kind_e;

  // leap year: divisible by 4, and either not by 25 or also by 16
  function automatic logic is_leap(input logic [YearW-1:0] y);
    logic [29:0] prod;
    logic [9:0]  q;
    logic [13:0] qx;
    logic [13:0] q25;
    logic        div25;
    prod  = 30'(y) * 30'(Recip25);
    q     = prod[29:Recip25Shift];
    qx    = {4'd0, q};
    q25   = (qx << 4) + (qx << 3) + qx;
    div25 = (y == q25);
    return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
  endfunction

  // number of days in a month, month assumed 1 to 12
  function automatic logic [DayW-1:0] month_length(input logic [MonthW-1:0] m,
                                                    input logic leap);
    logic [DayW-1:0] len;
    len = 5'd31;
    if (m == 4'd2) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11) begin
      len = 5'd30;
    end
    return len;
  endfunction

endpackage

/* hdl/calendar_date_counter.sv */
// Path: a request is held in the input register, then its result in the result
// register, whose contents stay on the outputs while the result channel stalls.
// Throughput: one request per cycle while the result channel does not stall;
// the date update for one request is a single pass of logic between the input
// register and the date registers.
// Reset: asynchronous, active low; the date returns to 1/1/2023, both
// stages empty.
// ----------------------------------------------------------------------------
// calendar_date_counter
// Gregorian day/month/year counter with checked load, one-day increment and
// decrement, and saturation at the year bounds.
// ----------------------------------------------------------------------------
module calendar_date_counter
  import cal_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // request channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        kind_i,
  input  logic [DayW-1:0]   load_day_i,
  input  logic [MonthW-1:0] load_month_i,
  input  logic [YearW-1:0]  load_year_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DayW-1:0]   day_o,
  output logic [MonthW-1:0] month_o,
  output logic [YearW-1:0]  year_o,
  output logic              load_ok_o
);

  logic              in_full_q;
  logic [1:0]        kind_q;
  logic [DayW-1:0]   ld_day_q;
  logic [MonthW-1:0] ld_month_q;
  logic [YearW-1:0]  ld_year_q;

  logic [DayW-1:0]   cur_day_q, cur_day_d;
  logic [MonthW-1:0] cur_month_q, cur_month_d;
  logic [YearW-1:0]  cur_year_q, cur_year_d;
  logic              load_ok_d;

  logic              out_valid_q;
  logic [DayW-1:0]   day_q;
  logic [MonthW-1:0] month_q;
  logic [YearW-1:0]  year_q;
  logic              load_ok_q;

  logic              advance;
  logic              in_take;
  logic              cur_leap;
  logic              ld_leap;
  logic              ld_valid;
  logic [MonthW-1:0] prev_month;

  // stage handshake
  assign advance    = in_full_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_full_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
    end else if (in_take) begin
      in_full_q <= 1'b1;
    end else if (advance) begin
      in_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      kind_q     <= kind_i;
      ld_day_q   <= load_day_i;
      ld_month_q <= load_month_i;
      ld_year_q  <= load_year_i;
    end
  end

  // load check
  assign ld_leap  = is_leap(ld_year_q);
  assign ld_valid = (ld_month_q >= 4'd1) && (ld_month_q <= 4'd12) &&
                    (ld_year_q >= YearMinLoad) && (ld_year_q <= YearMax) &&
                    (ld_day_q >= 5'd1) &&
                    (ld_day_q <= month_length(ld_month_q, ld_leap));

  assign cur_leap   = is_leap(cur_year_q);
  assign prev_month = cur_month_q - 4'd1;

  // next date
  always_comb begin
    cur_day_d   = cur_day_q;
    cur_month_d = cur_month_q;
    cur_year_d  = cur_year_q;
    load_ok_d   = 1'b0;
    unique case (kind_e'(kind_q))
      KIND_LOAD: begin
        if (ld_valid) begin
          cur_day_d   = ld_day_q;
          cur_month_d = ld_month_q;
          cur_year_d  = ld_year_q;
          load_ok_d   = 1'b1;
        end else begin
          cur_day_d   = DefaultDay;
          cur_month_d = DefaultMonth;
          cur_year_d  = DefaultYear;
        end
      end
      KIND_INC: begin
        if (cur_day_q < month_length(cur_month_q, cur_leap)) begin
          cur_day_d = cur_day_q + 5'd1;
        end else if (cur_month_q < 4'd12) begin
          cur_month_d = cur_month_q + 4'd1;
          cur_day_d   = 5'd1;
        end else if (cur_year_q < YearMax) begin
          cur_year_d  = cur_year_q + 14'd1;
          cur_month_d = 4'd1;
          cur_day_d   = 5'd1;
        end
      end
      KIND_DEC: begin
        if (cur_day_q > 5'd1) begin
          cur_day_d = cur_day_q - 5'd1;
        end else if (cur_month_q > 4'd1) begin
          cur_month_d = prev_month;
          cur_day_d   = month_length(prev_month, cur_leap);
        end else if (cur_year_q > 14'd0) begin
          cur_year_d  = cur_year_q - 14'd1;
          cur_month_d = 4'd12;
          cur_day_d   = 5'd31;
        end
      end
      default: begin
        // unused kind leaves the date as it is
      end
    endcase
  end

  // date state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_day_q   <= DefaultDay;
      cur_month_q <= DefaultMonth;
      cur_year_q  <= DefaultYear;
    end else if (advance) begin
      cur_day_q   <= cur_day_d;
      cur_month_q <= cur_month_d;
      cur_year_q  <= cur_year_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      day_q     <= cur_day_d;
      month_q   <= cur_month_d;
      year_q    <= cur_year_d;
      load_ok_q <= load_ok_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign day_o       = day_q;
  assign month_o     = month_q;
  assign year_o      = year_q;
  assign load_ok_o   = load_ok_q;

endmodule

/* hdl/cal_checker.sv */
// ----------------------------------------------------------------------------
// cal_checker
// Port-level checks on the calendar date counter's result channel.
// ----------------------------------------------------------------------------
module cal_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [4:0]  day_o,
  input logic [3:0]  month_o,
  input logic [13:0] year_o,
  input logic        load_ok_o
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(day_o) &&
    $stable(month_o) && $stable(year_o) && $stable(load_ok_o))
    else $error("stalled result changed");

  // every reported date is in range
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> day_o >= 5'd1 && month_o >= 4'd1 && month_o <= 4'd12 &&
    year_o <= 14'd9999)
    else $error("date out of range");

  // a short month never shows day 31, february never beyond 29
  a_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(day_o == 5'd31 && (month_o == 4'd2 || month_o == 4'd4 ||
    month_o == 4'd6 || month_o == 4'd9 || month_o == 4'd11)) &&
    !(day_o > 5'd29 && month_o == 4'd2))
    else $error("day exceeds month length");

  // an accepted load carries a year within the load bounds
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && load_ok_o |-> year_o >= 14'd1900)
    else $error("accepted load below year bound");

endmodule

bind calendar_date_counter cal_checker u_cal_checker (.*);
